@@ design/lsr_pkg.sv @@
// Shared types and constants for the literal string find-and-replace block.
package lsr_pkg;

  localparam int WIN_DEPTH   = 8;
  localparam int REP_MAX     = 8;
  localparam int PAT_MAX_DEF = 8;
  localparam int QDEPTH      = 2;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_PATTERN = 2'd0,
    REG_SEARCH_LENGTH  = 2'd1,
    REG_REPLACE_TEXT   = 2'd2,
    REG_REPLACE_LENGTH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       last;
  } out_item_t;

  // One accepted input turned into a burst of up to eight output bytes.
  typedef struct packed {
    logic [8*WIN_DEPTH-1:0] bytes;
    logic [3:0]             count;
    logic                   eos;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

endpackage

@@ design/lsr_front.sv @@
// Front end: configuration registers, match window and burst classification.
module lsr_front import lsr_pkg::*; #(
  parameter int PAT_MAX = PAT_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  in_item_t             src_item,
  input  logic                 q_full,
  output logic                 push,
  output job_t                 push_job
);

  logic [63:0] search_pattern;
  logic [3:0]  search_length;
  logic [63:0] replace_text;
  logic [3:0]  replace_length;

  logic [7:0] window [WIN_DEPTH];
  logic [7:0] window_next [WIN_DEPTH];
  logic [7:0] w_ins [WIN_DEPTH];
  logic [3:0] fill;
  logic [3:0] fill_next;

  logic [3:0] len;
  logic [3:0] rep;
  logic [3:0] base;
  logic [3:0] fill1;
  logic       full;
  logic       match;
  logic       eos;
  logic       accept;
  logic       cfg_we;
  logic       pat_we;
  logic [8*WIN_DEPTH-1:0] w_flat;

  assign cfg_ready = 1'b1;
  assign src_ready = !q_full;
  assign accept    = src_valid && src_ready;
  assign eos       = src_item.end_of_string;
  assign cfg_we    = cfg_valid && cfg_ready;
  // a new pattern or pattern length drops the pending window
  assign pat_we    = cfg_we && ((cfg_reg_t'(cfg_index) == REG_SEARCH_PATTERN) ||
                                (cfg_reg_t'(cfg_index) == REG_SEARCH_LENGTH));

  always_comb begin
    len = (search_length > 4'(PAT_MAX)) ? 4'(PAT_MAX) : search_length;
    rep = (replace_length > 4'(REP_MAX)) ? 4'(REP_MAX) : replace_length;
    base  = (fill >= len) ? 4'd0 : fill;
    fill1 = base + 4'd1;
    full  = (fill1 == len);
    match = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      w_ins[i] = (4'(i) == base) ? src_item.char_in : window[i];
      w_flat[8*i +: 8] = w_ins[i];
      if ((4'(i) < len) && (w_ins[i] != search_pattern[8*i +: 8])) begin
        match = 1'b0;
      end
    end

    window_next    = w_ins;
    fill_next      = fill;
    push_job.bytes = w_flat;
    push_job.count = 4'd0;
    push_job.eos   = eos;

    if (len == 4'd0) begin
      // copy mode: pass the byte straight through
      window_next    = window;
      push_job.bytes = {{(8*WIN_DEPTH-8){1'b0}}, src_item.char_in};
      push_job.count = 4'd1;
    end else if (full && match) begin
      push_job.bytes = replace_text;
      push_job.count = rep;
      fill_next      = 4'd0;
    end else if (full) begin
      // emit oldest byte, flush the rest on end of string
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        window_next[i] = w_ins[i+1];
      end
      push_job.count = eos ? len : 4'd1;
      fill_next      = eos ? 4'd0 : len - 4'd1;
    end else begin
      push_job.count = eos ? fill1 : 4'd0;
      fill_next      = eos ? 4'd0 : fill1;
    end
  end

  assign push = accept && ((push_job.count != 4'd0) || eos);

  always_ff @(posedge clk) begin
    if (rst) begin
      search_pattern <= '0;
      search_length  <= '0;
      replace_text   <= '0;
      replace_length <= '0;
      fill           <= '0;
    end else begin
      if (pat_we) begin
        fill <= '0;
      end else if (accept) begin
        fill <= fill_next;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SEARCH_PATTERN: search_pattern <= cfg_data;
          REG_SEARCH_LENGTH:  search_length  <= cfg_data[3:0];
          REG_REPLACE_TEXT:   replace_text   <= cfg_data;
          REG_REPLACE_LENGTH: replace_length <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

@@ design/lsr_queue.sv @@
// Short job queue between the front end and the output sequencer.
module lsr_queue import lsr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign full       = (count == CW'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.job   = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

@@ design/lsr_back.sv @@
// Back end: walks the head job and sends its bytes one word at a time.
module lsr_back import lsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_head_t   head,
  output logic      pop,
  output logic      dst_valid,
  input  logic      dst_ready,
  output out_item_t dst_item
);

  localparam int IW = $clog2(WIN_DEPTH);

  logic [IW-1:0] idx;
  logic          final_word;
  logic          empty_job;
  logic          take;

  assign empty_job  = (head.job.count == 4'd0);
  assign final_word = empty_job || ({{(4-IW){1'b0}}, idx} == head.job.count - 4'd1);
  assign dst_valid  = head.valid;
  assign take       = dst_valid && dst_ready;
  assign pop        = take && final_word;

  always_comb begin
    dst_item.char_out   = empty_job ? 8'd0 : head.job.bytes[8*idx +: 8];
    dst_item.char_valid = !empty_job;
    dst_item.last       = head.job.eos && final_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop) begin
      idx <= '0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

@@ design/literal_string_replace.sv @@
// Literal find-and-replace: top level joining front end, job queue and output sequencer.
// A result word is offered once its job, registered in the two-entry job queue, reaches
// the queue head. Throughput: one input word per cycle while each yields at most one
// byte and the output accepts; a word that yields n bytes (n up to 8) holds the output
// sequencer until all n are sent, and the job queue backpressures the input once full.
// Reset (rst, synchronous): clears all configuration registers, window fill and queue.
module literal_string_replace import lsr_pkg::*; #(
  parameter int PAT_MAX = PAT_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 src_valid,
  output logic                 src_ready,
  input  in_item_t             src_item,
  output logic                 dst_valid,
  input  logic                 dst_ready,
  output out_item_t            dst_item
);

  logic    q_full;
  logic    push;
  job_t    push_job;
  logic    pop;
  q_head_t head;

  lsr_front #(
    .PAT_MAX(PAT_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_item (src_item),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  lsr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .head    (head)
  );

  lsr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .dst_item (dst_item)
  );

endmodule
